// ----- hdl/gls_pkg.sv -----
`timescale 1ns / 1ps

package gls_pkg;

	// Fixed field widths of the stream items
	localparam int IDX_W       = 10;
	localparam int FIELD_VAL_W = 32;
	localparam int S_TDATA_W   = 96;
	localparam int M_TDATA_W   = 16;

	// Defaults of the top-level parameters
	localparam int DEF_TABLE_DEPTH = 1024;
	localparam int DEF_VALUE_WIDTH = 32;

	// Request kinds carried on s_tuser
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic [IDX_W-1:0]       start_index;
		logic [IDX_W-1:0]       upper_index;
		logic [FIELD_VAL_W-1:0] query_value;
	} gls_query_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GALLOP,
		ST_BSTART,
		ST_BINARY,
		ST_FINISH
	} gls_state_t;

endpackage

// ----- hdl/gls_ram.sv -----
`timescale 1ns / 1ps

module gls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hdl/gls_seq.sv -----
`timescale 1ns / 1ps

module gls_seq #(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  gls_pkg::gls_query_t            req,
	output logic                           rd_en,
	output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
	input  logic [VALUE_WIDTH-1:0]         rd_data,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [gls_pkg::IDX_W-1:0]      res_index
);

	import gls_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int W  = (AW > IDX_W) ? AW : IDX_W;
	// two spare bits: probe and step may run past the upper index by up to 2x
	localparam int CW = W + 2;
	localparam logic [CW-1:0] MAX_IDX = CW'(TABLE_DEPTH - 1);

	gls_state_t state_q, state_d;

	logic [CW-1:0]          lo_q, lo_d;
	logic [CW-1:0]          hi_q, hi_d;
	logic [CW-1:0]          probe_q, probe_d;
	logic [CW-1:0]          step_q, step_d;
	logic [CW-1:0]          upper_q, upper_d;
	logic [VALUE_WIDTH-1:0] query_q, query_d;
	logic                   res_valid_q;
	logic [IDX_W-1:0]       res_index_q;
	logic                   res_load;

	logic [CW-1:0]          upper_ext, upper_sat, start_ext, first_probe;
	logic [CW-1:0]          next_probe, mid;
	logic [63:0]            query_wide;
	logic [CW-1:0]          rd_idx;

	assign upper_ext   = CW'(req.upper_index);
	assign upper_sat   = (upper_ext > MAX_IDX) ? MAX_IDX : upper_ext;
	assign start_ext   = CW'(req.start_index);
	assign first_probe = start_ext + CW'(1);
	assign query_wide  = 64'(req.query_value);
	assign next_probe  = probe_q + step_q;
	assign mid         = lo_q + ((hi_q - lo_q) >> 1);

	assign req_ready = (state_q == ST_IDLE);
	assign rd_addr   = rd_idx[AW-1:0];
	assign res_valid = res_valid_q;
	assign res_index = res_index_q;

	always_comb begin
		state_d  = state_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		probe_d  = probe_q;
		step_d   = step_q;
		upper_d  = upper_q;
		query_d  = query_q;
		rd_en    = 1'b0;
		rd_idx   = probe_q;
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					lo_d    = start_ext;
					probe_d = first_probe;
					step_d  = CW'(2);
					upper_d = upper_sat;
					query_d = query_wide[VALUE_WIDTH-1:0];
					rd_idx  = first_probe;
					// start at or past upper: nothing to probe, answer is the start
					if (first_probe <= upper_sat) begin
						rd_en   = 1'b1;
						state_d = ST_GALLOP;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_GALLOP: begin
				if (rd_data <= query_q) begin
					lo_d    = probe_q;
					probe_d = next_probe;
					step_d  = step_q << 1;
					rd_idx  = next_probe;
					if (next_probe <= upper_q) begin
						rd_en = 1'b1;
					end else begin
						hi_d    = upper_q + CW'(1);
						state_d = ST_BSTART;
					end
				end else begin
					hi_d    = probe_q;
					state_d = ST_BSTART;
				end
			end
			ST_BSTART: begin
				rd_idx = mid;
				if (lo_q < mid) begin
					rd_en   = 1'b1;
					probe_d = mid;
					state_d = ST_BINARY;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_BINARY: begin
				if (rd_data > query_q) begin
					hi_d = probe_q;
				end else begin
					lo_d = probe_q;
				end
				state_d = ST_BSTART;
			end
			ST_FINISH: begin
				// hold until the output register is free
				if (!res_valid_q || res_ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		probe_q <= probe_d;
		step_q  <= step_d;
		upper_q <= upper_d;
		query_q <= query_d;
		if (res_load) begin
			res_index_q <= lo_q[IDX_W-1:0];
		end
	end

endmodule

// ----- hdl/galloping_left_bound_search.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Fields (lowest bit first)                                      Carries
// s_*      in   tuser: action; tdata: entry_index, entry_value, start_index,   load or query
//               upper_index, query_value, 2 pad bits
// m_*      out  tdata: bound_index, 6 pad bits                                 one per query
//
// A load request writes one table entry; loads beyond the table are dropped.
// A query runs G galloping probes (one memory read per cycle) and then B binary probes, each a
// midpoint read in ST_BSTART followed by a compare in ST_BINARY. The single table memory port
// sets that pace; one request is in work at a time.
// Reset clears only the sequencer state and the output valid; the table is undefined until written.
// A finished result waits in the output register while the next request is taken; a query
// that finishes before that register drains holds in its last state.
module galloping_left_bound_search #(
	parameter int TABLE_DEPTH = gls_pkg::DEF_TABLE_DEPTH,
	parameter int VALUE_WIDTH = gls_pkg::DEF_VALUE_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// tuser: action
	input  logic                            s_tuser,
	// tdata: entry_index[9:0], entry_value[41:10], start_index[51:42],
	//        upper_index[61:52], query_value[93:62], zero pad[95:94]
	input  logic [gls_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// tdata: bound_index[9:0], zero pad[15:10]
	output logic [gls_pkg::M_TDATA_W-1:0]   m_tdata
);

	import gls_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int W  = (AW > IDX_W) ? AW : IDX_W;
	localparam logic [W-1:0] MAX_IDX = W'(TABLE_DEPTH - 1);

	localparam int ENTRY_IDX_LSB = 0;
	localparam int ENTRY_VAL_LSB = ENTRY_IDX_LSB + IDX_W;
	localparam int START_LSB     = ENTRY_VAL_LSB + FIELD_VAL_W;
	localparam int UPPER_LSB     = START_LSB + IDX_W;
	localparam int QUERY_LSB     = UPPER_LSB + IDX_W;

	logic [IDX_W-1:0]       entry_index;
	logic [FIELD_VAL_W-1:0] entry_value;
	logic [W-1:0]           entry_ext;
	logic [63:0]            value_wide;
	gls_query_t             query;

	logic                   accept;
	logic                   wr_en;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic [VALUE_WIDTH-1:0] rd_data;
	logic                   seq_ready;
	logic [IDX_W-1:0]       bound_index;

	// Unpack the request
	assign entry_index       = s_tdata[ENTRY_IDX_LSB +: IDX_W];
	assign entry_value       = s_tdata[ENTRY_VAL_LSB +: FIELD_VAL_W];
	assign query.start_index = s_tdata[START_LSB +: IDX_W];
	assign query.upper_index = s_tdata[UPPER_LSB +: IDX_W];
	assign query.query_value = s_tdata[QUERY_LSB +: FIELD_VAL_W];

	// Loads and queries are both taken only while the sequencer is idle
	assign s_tready = seq_ready;
	assign accept   = s_tvalid && s_tready;

	// Drop loads that fall past the end of the table; cut values to the stored width
	assign entry_ext  = W'(entry_index);
	assign wr_en      = accept && (s_tuser == ACT_LOAD) && (entry_ext <= MAX_IDX);
	assign value_wide = 64'(entry_value);

	gls_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (entry_ext[AW-1:0]),
		.wr_data (value_wide[VALUE_WIDTH-1:0]),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	gls_seq #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid && (s_tuser == ACT_QUERY)),
		.req_ready (seq_ready),
		.req       (query),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_index (bound_index)
	);

	assign m_tdata = M_TDATA_W'(bound_index);

endmodule
